### rtl/multi_voice_sample_mixer_top_assert.svh
// Assertion macros for the sample mixer checker.
`ifndef MULTI_VOICE_SAMPLE_MIXER_TOP_ASSERT_SVH
`define MULTI_VOICE_SAMPLE_MIXER_TOP_ASSERT_SVH

`define MVSM_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define MVSM_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

### rtl/mvsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mvsm_pkg;

  localparam int Voices = 32;
  localparam int VoiceBits = 5;
  localparam int CountBits = 6;
  localparam int SampleBits = 16;
  localparam int PanSteps = 256;
  localparam int PanBits = 9;

  localparam logic [1:0] ModeWrite = 2'd0;
  localparam logic [1:0] ModePlay = 2'd1;
  localparam logic [1:0] ModeRender = 2'd2;
  localparam logic [1:0] ModeStop = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [15:0] address;
    logic signed [15:0] sample_value;
    logic [15:0] frame_count;
    logic stereo;
    logic [15:0] volume;
    logic [23:0] pitch;
    logic signed [15:0] pan;
    logic loop;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic status;
    logic [5:0] active_voices;
  } out_word_t;

  // Voice record stored in the voice memory.
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] length;
    logic is_stereo;
    logic loops;
    logic [31:0] cursor;
    logic [23:0] step;
    logic [16:0] left_gain;
    logic [16:0] right_gain;
  } voice_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VREAD,
    ST_VCHECK,
    ST_SREAD,
    ST_SWAIT,
    ST_LERP,
    ST_MUL,
    ST_ACC,
    ST_GAIN,
    ST_PLAYW,
    ST_FINISH,
    ST_OUT
  } state_t;

  // Integer Taylor series for sin(k*pi/(2*PanSteps)) in Q15.
  function automatic logic [16:0] sine_q15(input int unsigned k);
    logic [63:0] x;
    logic [63:0] term;
    longint sum;
    longint r;
    x = (64'(k) * 64'd1686629713) / 64'(PanSteps);
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 16384) >>> 15;
    if (r > 32768) r = 32768;
    return 17'(r);
  endfunction

endpackage
`default_nettype wire

### rtl/mvsm_voice_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mvsm_voice_ram (
  input wire logic clk,
  input wire logic we,
  input wire logic [mvsm_pkg::VoiceBits-1:0] waddr,
  input wire mvsm_pkg::voice_t wdata,
  input wire logic [mvsm_pkg::VoiceBits-1:0] raddr,
  output mvsm_pkg::voice_t rdata
);
  import mvsm_pkg::*;

  voice_t mem [Voices];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/mvsm_sample_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mvsm_sample_ram (
  input wire logic clk,
  input wire logic we,
  input wire logic [15:0] waddr,
  input wire logic signed [15:0] wdata,
  input wire logic [15:0] raddr,
  output logic signed [15:0] rdata
);
  import mvsm_pkg::*;

  logic signed [SampleBits-1:0] mem [65536];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/mvsm_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module mvsm_engine (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire mvsm_pkg::in_word_t in_word,
  output logic out_valid,
  input wire logic out_stall,
  output mvsm_pkg::out_word_t out_word,
  input wire logic [15:0] master
);
  import mvsm_pkg::*;

  state_t state, state_next;
  in_word_t cmd;
  logic [Voices-1:0] active;
  logic [VoiceBits-1:0] vidx;
  logic [VoiceBits-1:0] slot;
  logic slot_found;
  logic [1:0] sidx;
  logic signed [15:0] smp [4];
  voice_t vrec;
  voice_t vram_rdata;
  voice_t vram_wdata;
  logic vram_we;
  logic signed [15:0] sram_rdata;
  logic [15:0] sram_raddr;
  logic [15:0] cur_idx;
  logic [15:0] nxt_idx;
  logic signed [15:0] sl, sr;
  logic [15:0] frac;
  logic [16:0] gl, gr;
  logic signed [35:0] pl, pr;
  logic signed [40:0] lacc, racc;
  logic [16:0] pan_l, pan_r;
  logic [32:0] gmul_l, gmul_r;
  logic [PanBits-1:0] pidx;
  logic [16:0] pan_rom [PanSteps+1];
  out_word_t result;

  always_comb begin
    for (int k = 0; k <= PanSteps; k++) pan_rom[k] = sine_q15(k);
  end

  mvsm_voice_ram u_vram (
    .clk(clk), .we(vram_we), .waddr(vidx), .wdata(vram_wdata),
    .raddr(vidx), .rdata(vram_rdata)
  );

  mvsm_sample_ram u_sram (
    .clk(clk), .we(in_valid && !in_stall && in_word.mode == ModeWrite),
    .waddr(in_word.address), .wdata(in_word.sample_value),
    .raddr(sram_raddr), .rdata(sram_rdata)
  );

  always_comb begin
    slot_found = 1'b0;
    slot = '0;
    for (int v = Voices - 1; v >= 0; v--) begin
      if (!active[v]) begin
        slot_found = 1'b1;
        slot = VoiceBits'(v);
      end
    end
  end

  function automatic logic signed [15:0] lerp16(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic [15:0] f);
    logic signed [16:0] d;
    logic signed [34:0] m;
    d = 17'(b) - 17'(a);
    m = 35'(d) * $signed({19'd0, f}) + 35'sd32768;
    return 16'(17'(a) + 17'(m >>> 16));
  endfunction

  always_comb begin
    cur_idx = vrec.cursor[31:16];
    nxt_idx = (17'(cur_idx) + 17'd1 < 17'(vrec.length)) ? cur_idx + 16'd1 : cur_idx;
    frac = vrec.cursor[15:0];
    case (sidx)
      2'd0: sram_raddr = vrec.start + (vrec.is_stereo ? {cur_idx[14:0], 1'b0} : cur_idx);
      2'd1: sram_raddr = vrec.start + (vrec.is_stereo ? {nxt_idx[14:0], 1'b0} : nxt_idx);
      2'd2: sram_raddr = vrec.start + {cur_idx[14:0], 1'b1};
      default: sram_raddr = vrec.start + {nxt_idx[14:0], 1'b1};
    endcase
    pidx = PanBits'((25'({~cmd.pan[15], cmd.pan[14:0]}) * 25'd256 + 25'd32768) >> 16);
    if (pidx > PanBits'(PanSteps)) pidx = PanBits'(PanSteps);
    pan_r = pan_rom[pidx];
    pan_l = pan_rom[PanBits'(PanSteps) - pidx];
  end

  always_comb begin
    voice_t w;
    logic [32:0] c;
    w = vrec;
    vram_we = 1'b0;
    c = 33'(vrec.cursor) + 33'(vrec.step);
    if (state == ST_ACC) begin
      w.cursor = c[32] ? 32'hFFFFFFFF : c[31:0];
      vram_we = 1'b1;
    end else if (state == ST_PLAYW && !result.status) begin
      w.start = cmd.address;
      w.length = cmd.frame_count;
      w.is_stereo = cmd.stereo;
      w.loops = cmd.loop;
      w.cursor = '0;
      w.step = (cmd.pitch == '0) ? 24'h010000 : cmd.pitch;
      w.left_gain = 17'((gmul_l + 33'd16384) >> 15);
      w.right_gain = 17'((gmul_r + 33'd16384) >> 15);
      vram_we = 1'b1;
    end
    vram_wdata = w;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) begin
        case (in_word.mode)
          ModeRender: state_next = ST_SCAN;
          ModePlay: state_next = ST_GAIN;
          default: state_next = ST_FINISH;
        endcase
      end
      ST_SCAN: state_next = active[vidx] ? ST_VREAD : ST_ACC;
      ST_VREAD: state_next = ST_VCHECK;
      ST_VCHECK: state_next = ST_SREAD;
      ST_SREAD: state_next = ST_SWAIT;
      ST_SWAIT: state_next = (sidx == 2'd3 || (!vrec.is_stereo && sidx == 2'd1)) ?
                             ST_LERP : ST_SREAD;
      ST_LERP: state_next = ST_MUL;
      ST_MUL: state_next = ST_ACC;
      ST_ACC: state_next = (vidx == VoiceBits'(Voices - 1)) ? ST_FINISH : ST_SCAN;
      ST_GAIN: state_next = ST_PLAYW;
      ST_PLAYW: state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign out_word = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      active <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_valid && in_word.mode == ModeStop) active <= '0;
      if (state == ST_VCHECK && vram_rdata.cursor[31:16] >= vram_rdata.length &&
          !vram_rdata.loops) begin
        active[vidx] <= 1'b0;
      end
      if (state == ST_PLAYW && !result.status) active[vidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd <= in_word;
        vidx <= '0;
        lacc <= '0;
        racc <= '0;
        result.status <= 1'b0;
      end
      ST_VCHECK: begin
        voice_t vc;
        vc = vram_rdata;
        if (vram_rdata.cursor[31:16] >= vram_rdata.length) begin
          if (vram_rdata.loops) begin
            vc.cursor = '0;
          end else begin
            vc.left_gain = '0;
            vc.right_gain = '0;
            vc.step = '0;
          end
        end
        vrec <= vc;
        sidx <= 2'd0;
      end
      ST_SWAIT: begin
        smp[sidx] <= sram_rdata;
        sidx <= (vrec.is_stereo || sidx != 2'd1) ? sidx + 2'd1 : 2'd3;
        if (!vrec.is_stereo && sidx == 2'd1) begin
          smp[2] <= smp[0];
          smp[3] <= sram_rdata;
        end
      end
      ST_LERP: begin
        sl <= lerp16(smp[0], smp[1], frac);
        sr <= lerp16(smp[2], smp[3], frac);
        gl <= 17'((34'(vrec.left_gain) * 34'(master) + 34'd16384) >> 15);
        gr <= 17'((34'(vrec.right_gain) * 34'(master) + 34'd16384) >> 15);
      end
      ST_MUL: begin
        pl <= sl * $signed({1'b0, gl});
        pr <= sr * $signed({1'b0, gr});
      end
      ST_ACC: begin
        if (active[vidx]) begin
          lacc <= lacc + 41'(pl);
          racc <= racc + 41'(pr);
        end
        vidx <= vidx + 1'b1;
        pl <= '0;
        pr <= '0;
      end
      ST_GAIN: begin
        gmul_l <= 33'(pan_l) * 33'(cmd.volume);
        gmul_r <= 33'(pan_r) * 33'(cmd.volume);
        vidx <= slot;
        if (!slot_found || cmd.frame_count == '0) result.status <= 1'b1;
      end
      ST_FINISH: begin
        logic signed [40:0] ls, rs;
        ls = (lacc + 41'sd16384) >>> 15;
        rs = (racc + 41'sd16384) >>> 15;
        if (cmd.mode == ModeRender) begin
          result.left_out <= (ls > 41'sd32767) ? 16'sd32767 :
                             (ls < -41'sd32767) ? -16'sd32767 : 16'(ls);
          result.right_out <= (rs > 41'sd32767) ? 16'sd32767 :
                              (rs < -41'sd32767) ? -16'sd32767 : 16'(rs);
        end else begin
          result.left_out <= '0;
          result.right_out <= '0;
        end
        result.active_voices <= CountBits'($countones(active));
      end
      default: ;
    endcase
    if (state == ST_SCAN && !active[vidx]) begin
      pl <= '0;
      pr <= '0;
    end
  end
endmodule
`default_nettype wire

### rtl/multi_voice_sample_mixer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Multi-voice sample mixer.
// Input channel: in_valid/in_stall carrying in_word (mode, address, sample,
// clip settings). Output channel: out_valid/out_stall carrying out_word,
// one result word per input word. Config channel: cfg_valid/cfg_ready
// writes the master volume, saturated to 32768; write it only while idle.
// A render walks all 32 voices in the voice memory. Each sample read goes
// through the one sample memory read port, four reads per stereo voice.
// One word is in flight at a time; in_stall stays high until its result is
// taken.
// Reset clears all voices to inactive and master volume to 32768; sample
// memory content is undefined until written.
// While out_stall is high the result holds and no input is taken.
module multi_voice_sample_mixer_top (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_stall,
  input wire mvsm_pkg::in_word_t in_word,
  output logic out_valid,
  input wire logic out_stall,
  output mvsm_pkg::out_word_t out_word,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [15:0] cfg_data
);
  import mvsm_pkg::*;

  logic [15:0] master;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      master <= 16'd32768;
    end else if (cfg_valid) begin
      master <= (cfg_data > 16'd32768) ? 16'd32768 : cfg_data;
    end
  end

  mvsm_engine u_engine (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .master(master)
  );
endmodule
`default_nettype wire

### rtl/mvsm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "multi_voice_sample_mixer_top_assert.svh"
module mvsm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire mvsm_pkg::out_word_t out_word
);
  import mvsm_pkg::*;

  `MVSM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word), "output word changed while stalled")
  `MVSM_ASSERT_IMPL(a_busy, clk, rst, out_valid |-> in_stall, "input taken while result pending")
  `MVSM_ASSERT_IMPL(a_count, clk, rst, out_valid |-> out_word.active_voices <= 6'(Voices), "active count too large")
  `MVSM_ASSERT_NEXT(a_take, clk, rst, in_valid && !in_stall, in_stall, "second word taken at once")
endmodule

bind multi_voice_sample_mixer_top mvsm_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);
`default_nettype wire

### tb/multi_voice_sample_mixer_top_tb.sv
`timescale 1ns / 1ps
module multi_voice_sample_mixer_top_tb;
  import mvsm_pkg::*;

  localparam int NumVoices = 32;
  localparam int PanN = 256;
  localparam longint CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  multi_voice_sample_mixer_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mixer mirror
  bit          mx_active[NumVoices];
  logic [15:0] mx_start[NumVoices];
  logic [15:0] mx_len[NumVoices];
  bit          mx_stereo[NumVoices];
  bit          mx_loop[NumVoices];
  logic [31:0] mx_cursor[NumVoices];
  logic [23:0] mx_step[NumVoices];
  longint      mx_lgain[NumVoices];
  longint      mx_rgain[NumVoices];
  logic signed [15:0] sample_mem[int];
  longint      master_gain;
  longint      quarter_sine[PanN + 1];

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int  errors = 0;
  int  send_idle = 20;
  int  recv_idle = 67;
  bit  hold_send = 1'b0;
  bit  stim_done = 1'b0;
  longint cycles = 0;
  logic [15:0] written_addr[$];

  function automatic longint floor_div(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v + (longint'(1) << s) - 1) >>> s);
  endfunction

  function automatic longint quarter_sine_at(int k);
    longint unsigned x, term;
    longint sum, r;
    x = (longint'(k) * 64'd1686629713) / PanN;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 16384) >>> 15;
    if (r > 32768) r = 32768;
    return r;
  endfunction

  function automatic longint read_sample(longint a);
    logic [15:0] k;
    k = a[15:0];
    return sample_mem.exists(k) ? longint'(sample_mem[k]) : 0;
  endfunction

  function automatic longint interp(longint a, longint b, longint frac);
    return a + floor_div((b - a) * frac + 32768, 16);
  endfunction

  function automatic logic signed [15:0] round_clamp(longint acc);
    longint s;
    s = floor_div(acc + 16384, 15);
    if (s > 32767) s = 32767;
    if (s < -32767) s = -32767;
    return 16'(s);
  endfunction

  function automatic out_word_t mix_word(in_word_t w);
    out_word_t r;
    longint lacc, racc, sl, sr, gl, gr, p, ai, bi;
    longint unsigned cur;
    int slot, pidx, cnt;
    logic [31:0] idx, nxt, frac;
    r = '0;
    lacc = 0;
    racc = 0;
    case (w.mode)
      ModeWrite: sample_mem[w.address] = w.sample_value;
      ModePlay: begin
        slot = -1;
        if (w.frame_count != 0)
          for (int v = 0; v < NumVoices; v++)
            if (!mx_active[v] && slot < 0) slot = v;
        if (slot < 0) r.status = 1'b1;
        else begin
          p = longint'(w.pan) + 32768;
          pidx = int'((p * PanN + 32768) >>> 16);
          if (pidx > PanN) pidx = PanN;
          mx_start[slot] = w.address;
          mx_len[slot] = w.frame_count;
          mx_stereo[slot] = w.stereo;
          mx_loop[slot] = w.loop;
          mx_cursor[slot] = '0;
          mx_step[slot] = (w.pitch != 0) ? w.pitch : 24'h010000;
          mx_lgain[slot] = (quarter_sine[PanN - pidx] * w.volume + 16384) >>> 15;
          mx_rgain[slot] = (quarter_sine[pidx] * w.volume + 16384) >>> 15;
          mx_active[slot] = 1'b1;
        end
      end
      ModeRender: begin
        for (int v = 0; v < NumVoices; v++) begin
          if (!mx_active[v]) continue;
          idx = mx_cursor[v] >> 16;
          if (idx >= mx_len[v]) begin
            if (!mx_loop[v]) begin
              mx_active[v] = 1'b0;
              continue;
            end
            mx_cursor[v] = '0;
            idx = '0;
          end
          frac = mx_cursor[v] & 32'hFFFF;
          nxt = (idx + 1 < mx_len[v]) ? idx + 1 : idx;
          if (mx_stereo[v]) begin
            ai = longint'(mx_start[v]) + 2 * longint'(idx);
            bi = longint'(mx_start[v]) + 2 * longint'(nxt);
            sl = interp(read_sample(ai), read_sample(bi), frac);
            sr = interp(read_sample(ai + 1), read_sample(bi + 1), frac);
          end else begin
            sl = interp(read_sample(longint'(mx_start[v]) + idx),
                        read_sample(longint'(mx_start[v]) + nxt), frac);
            sr = sl;
          end
          gl = (mx_lgain[v] * master_gain + 16384) >>> 15;
          gr = (mx_rgain[v] * master_gain + 16384) >>> 15;
          lacc += sl * gl;
          racc += sr * gr;
          cur = longint'(mx_cursor[v]) + longint'(mx_step[v]);
          mx_cursor[v] = (cur > 64'hFFFFFFFF) ? 32'hFFFFFFFF : cur[31:0];
        end
        r.left_out = round_clamp(lacc);
        r.right_out = round_clamp(racc);
      end
      default: for (int v = 0; v < NumVoices; v++) mx_active[v] = 1'b0;
    endcase
    cnt = 0;
    for (int v = 0; v < NumVoices; v++) if (mx_active[v]) cnt++;
    r.active_voices = 6'(cnt);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
      if (in_valid && !in_stall) begin
        expected_words.push_back(mix_word(in_word));
        void'(pending_words.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold
      end else if (pending_words.size() > 0 && !hold_send
                   && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_word <= pending_words[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("result word with none expected: %h", out_word);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_word.left_out !== e.left_out) begin
          $error("left_out expected %0d got %0d", e.left_out, out_word.left_out);
          errors++;
        end
        if (out_word.right_out !== e.right_out) begin
          $error("right_out expected %0d got %0d", e.right_out, out_word.right_out);
          errors++;
        end
        if (out_word.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_word.status);
          errors++;
        end
        if (out_word.active_voices !== e.active_voices) begin
          $error("active_voices expected %0d got %0d", e.active_voices,
                 out_word.active_voices);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_word_t blank_word(logic [1:0] m);
    in_word_t w;
    w = '0;
    w.mode = m;
    return w;
  endfunction

  function automatic in_word_t write_word(logic [15:0] a, logic [15:0] s);
    in_word_t w;
    w = in_word_t'({$urandom, $urandom, $urandom, $urandom});
    w.mode = ModeWrite;
    w.address = a;
    w.sample_value = s;
    return w;
  endfunction

  function automatic in_word_t play_word(logic [15:0] a, logic [15:0] n, bit st,
                                         logic [15:0] vol, logic [23:0] pit,
                                         logic [15:0] pn, bit lp);
    in_word_t w;
    w = in_word_t'({$urandom, $urandom, $urandom, $urandom});
    w.mode = ModePlay;
    w.address = a;
    w.frame_count = n;
    w.stereo = st;
    w.volume = vol;
    w.pitch = pit;
    w.pan = pn;
    w.loop = lp;
    return w;
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || expected_words.size() > 0 || in_valid)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_master(logic [15:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    master_gain = (v > 16'd32768) ? 32768 : v;
    @(posedge clk);
  endtask

  // Clips only read a window filled once at the start, so no unwritten read occurs.
  task automatic queue_random(int count);
    int m, r;
    for (int i = 0; i < count; i++) begin
      m = $urandom_range(99);
      if (m < 12) pending_words.push_back(write_word(16'($urandom_range(255)),
                                                     16'($urandom)));
      else if (m < 40) begin
        r = $urandom_range(9);
        pending_words.push_back(play_word(16'($urandom_range(100)),
          (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom_range(70)) :
                     16'($urandom_range(1, 12)),
          1'($urandom_range(1)), 16'($urandom),
          (r < 3) ? 24'($urandom) : 24'($urandom_range(0, 24'h3FFFF)),
          16'($urandom), 1'($urandom_range(1))));
      end else if (m < 97) pending_words.push_back(blank_word(ModeRender));
      else pending_words.push_back(blank_word(ModeStop));
    end
  endtask

  initial begin
    for (int k = 0; k <= PanN; k++) quarter_sine[k] = quarter_sine_at(k);
    master_gain = 32768;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_master(16'd32768);

    for (int a = 0; a < 256; a++) pending_words.push_back(write_word(16'(a), 16'($urandom)));
    pending_words.push_back(write_word(16'hFFFF, 16'h7FFF));
    pending_words.push_back(write_word(16'h0000, 16'h8000));
    pending_words.push_back(write_word(16'h0001, 16'h7FFF));
    drain();

    send_idle = 0;
    recv_idle = 0;
    pending_words.push_back(play_word(16'hFFFF, 16'd3, 1'b1, 16'hFFFF, 24'd0,
                                      16'sh8000, 1'b1));
    pending_words.push_back(play_word(16'd0, 16'd2, 1'b0, 16'hFFFF, 24'hFFFFFF,
                                      16'sh7FFF, 1'b0));
    pending_words.push_back(play_word(16'd5, 16'd0, 1'b0, 16'd100, 24'h8000, 16'd0, 1'b0));
    pending_words.push_back(play_word(16'd10, 16'hFFFF, 1'b0, 16'd0, 24'h000001,
                                      16'd0, 1'b1));
    for (int i = 0; i < 6; i++) pending_words.push_back(blank_word(ModeRender));
    for (int i = 0; i < 33; i++)
      pending_words.push_back(play_word(16'd0, 16'd1, 1'b0, 16'hFFFF, 24'h010000,
                                        16'($urandom), 1'b1));
    pending_words.push_back(blank_word(ModeRender));
    pending_words.push_back(blank_word(ModeStop));
    pending_words.push_back(blank_word(ModeRender));
    drain();

    send_idle = 20;
    recv_idle = 67;
    write_master(16'd0);
    queue_random(150);
    drain();
    write_master(16'hFFFF);
    queue_random(100);
    while (pending_words.size() > 50) @(posedge clk);
    hold_send = 1'b1;
    while (expected_words.size() > 0 || in_valid) @(posedge clk);
    hold_send = 1'b0;
    drain();

    send_idle = 67;
    recv_idle = 20;
    write_master(16'($urandom_range(32768)));
    queue_random(150);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_master(16'd32767);
    queue_random(150);
    drain();

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/mvsm_pkg.sv
rtl/mvsm_voice_ram.sv
rtl/mvsm_sample_ram.sv
rtl/mvsm_engine.sv
rtl/multi_voice_sample_mixer_top.sv
rtl/mvsm_checker.sv
tb/multi_voice_sample_mixer_top_tb.sv
